// ===== src/rolling_zscore_signal_assert.svh =====
// Assertion helpers for the RTL, included by zsc_back.
`ifndef ROLLING_ZSCORE_SIGNAL_ASSERT_SVH
`define ROLLING_ZSCORE_SIGNAL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ZSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/zsc_pkg.sv =====
package zsc_pkg;

  localparam int ZSC_WINDOW  = 8;   // default window length
  localparam int ZSC_PRICE_W = 24;  // Q16.8 price
  localparam int ZSC_DW      = 25;  // signed spread
  localparam int ZSC_MW      = 24;  // spread magnitude
  localparam int ZSC_TW      = 16;  // Q4.12 threshold
  localparam int ZSC_SIGW    = 3;
  localparam int ZSC_ZSHIFT  = 24;  // 2^24 scale from the Q4.12 squares
  localparam int ZSC_CHUNK   = 16;  // multiplier digit width
  localparam int ZSC_QDEPTH  = 2;
  localparam int ZSC_CFG_IDXW = 2;

  localparam logic [ZSC_CFG_IDXW-1:0] CFG_ENTRY = 2'd0;
  localparam logic [ZSC_CFG_IDXW-1:0] CFG_EXIT  = 2'd1;

  localparam logic [ZSC_TW-1:0] ENTRY_RESET = 16'd4096;
  localparam logic [ZSC_TW-1:0] EXIT_RESET  = 16'd3277;

  localparam logic [ZSC_SIGW-1:0] SIG_WARM  = 3'd0;
  localparam logic [ZSC_SIGW-1:0] SIG_LONG  = 3'd1;
  localparam logic [ZSC_SIGW-1:0] SIG_SHORT = 3'd2;
  localparam logic [ZSC_SIGW-1:0] SIG_CLOSE = 3'd3;
  localparam logic [ZSC_SIGW-1:0] SIG_NONE  = 3'd4;

  typedef struct packed {
    logic                     warm;
    logic signed [ZSC_DW-1:0] spread;
  } zsc_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } zsc_mul_stat_t;

endpackage

// ===== src/zsc_front.sv =====
module zsc_front import zsc_pkg::*; #(
  parameter int WINDOW = ZSC_WINDOW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [ZSC_PRICE_W-1:0] price_a,
  input  logic [ZSC_PRICE_W-1:0] price_b,
  input  logic                   q_full,
  output logic                   q_push,
  output zsc_item_t              q_item
);

  localparam int FCW = $clog2(WINDOW + 1);

  logic [FCW-1:0] fill;
  logic           warm;

  assign warm       = fill < FCW'(WINDOW);
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  assign q_item.warm   = warm;
  assign q_item.spread = $signed({1'b0, price_a}) - $signed({1'b0, price_b});

  // saturating fill count: tags the first WINDOW items as warm-up
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (q_push && warm) begin
      fill <= fill + 1'b1;
    end
  end

endmodule

// ===== src/zsc_queue.sv =====
module zsc_queue import zsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  zsc_item_t din,
  input  logic      pop,
  output zsc_item_t dout,
  output logic      full,
  output logic      empty
);

  localparam int QAW = $clog2(ZSC_QDEPTH);
  localparam int QCW = $clog2(ZSC_QDEPTH + 1);

  zsc_item_t      entries [ZSC_QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full  = count == QCW'(ZSC_QDEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(ZSC_QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(ZSC_QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ===== src/zsc_mul.sv =====
module zsc_mul import zsc_pkg::*; #(
  parameter int AW = 54,
  parameter int BW = 32,
  parameter int PW = AW + ((BW + ZSC_CHUNK - 1) / ZSC_CHUNK) * ZSC_CHUNK
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output zsc_mul_stat_t stat,
  output logic [PW-1:0] product
);

  localparam int NCH  = (BW + ZSC_CHUNK - 1) / ZSC_CHUNK;
  localparam int BPW  = NCH * ZSC_CHUNK;
  localparam int CNTW = $clog2(NCH + 1);

  logic [AW-1:0]           a_r;
  logic [BPW-1:0]          b_r;
  logic [PW-1:0]           acc;
  logic [CNTW-1:0]         cnt;
  logic                    busy;
  logic                    done;
  logic [AW+ZSC_CHUNK-1:0] pp;

  // one digit of b per cycle, most significant first
  assign pp      = a_r * b_r[BPW-1 -: ZSC_CHUNK];
  assign product = acc;
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NCH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BPW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << ZSC_CHUNK) + PW'(pp);
      b_r <= b_r << ZSC_CHUNK;
    end
  end

endmodule

// ===== src/zsc_back.sv =====
`include "rolling_zscore_signal_assert.svh"

module zsc_back import zsc_pkg::*; #(
  parameter int WINDOW = ZSC_WINDOW
) (
  input  logic                clk,
  input  logic                rst,
  input  zsc_item_t           q_item,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [ZSC_TW-1:0]   entry_thr,
  input  logic [ZSC_TW-1:0]   exit_thr,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [ZSC_SIGW-1:0] signal
);

  localparam int CLW  = $clog2(WINDOW);
  localparam int SW   = ZSC_DW + CLW;           // signed window sum
  localparam int SMW  = ZSC_MW + CLW;           // |sum|
  localparam int QW   = 2 * ZSC_MW + CLW;       // sum of squares
  localparam int EMW  = ZSC_DW + CLW;           // |N*d - S|
  localparam int EW   = EMW + 1;
  localparam int VW   = 2 * ZSC_MW + 2 * CLW;   // N*Q - S*S
  localparam int CW   = 2 * ZSC_TW;             // squared threshold
  localparam int AW   = VW;
  localparam int BW   = (EMW > CW) ? EMW : CW;
  localparam int BPW  = ((BW + ZSC_CHUNK - 1) / ZSC_CHUNK) * ZSC_CHUNK;
  localparam int PW   = AW + BPW;
  localparam int LHW  = 2 * EMW + ZSC_ZSHIFT;
  localparam int CMPW = VW + CW;
  localparam int SQW  = 2 * ZSC_MW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [3:0] OP_EE  = 4'd0;  // e*e
  localparam logic [3:0] OP_NQ  = 4'd1;  // N*Q
  localparam logic [3:0] OP_SS  = 4'd2;  // S*S
  localparam logic [3:0] OP_TT  = 4'd3;  // entry^2
  localparam logic [3:0] OP_VT  = 4'd4;  // V*entry^2
  localparam logic [3:0] OP_XX  = 4'd5;  // exit^2
  localparam logic [3:0] OP_VX  = 4'd6;  // V*exit^2
  localparam logic [3:0] OP_OLD = 4'd7;  // old^2
  localparam logic [3:0] OP_DD  = 4'd8;  // d^2

  logic [2:0]               state;
  logic [3:0]               op;
  logic [3:0]               op_next;
  logic [CLW-1:0]           slot;
  logic signed [SW-1:0]     sum;
  logic [QW-1:0]            sqsum;

  logic signed [ZSC_DW-1:0] spread;
  logic                     warm;
  logic signed [ZSC_DW-1:0] old_r;
  logic signed [EW-1:0]     e_r;
  logic [LHW-1:0]           lhs;
  logic [VW-1:0]            v;
  logic [CW-1:0]            coef;
  logic                     enter_flag;
  logic                     close_flag;
  logic [SQW-1:0]           oldsq;
  logic [SQW-1:0]           dsq;

  logic signed [ZSC_DW-1:0] win_mem [WINDOW];
  logic signed [ZSC_DW-1:0] mem_q;

  logic signed [EW-1:0]     e_calc;
  logic signed [EW-1:0]     e_abs;
  logic signed [SW-1:0]     sum_abs;
  logic signed [ZSC_DW-1:0] old_abs;
  logic signed [ZSC_DW-1:0] spread_abs;
  logic [CMPW-1:0]          lhs_ext;
  logic [AW-1:0]            mul_a;
  logic [BW-1:0]            mul_b;
  logic                     mul_start;
  zsc_mul_stat_t            mst;
  logic [PW-1:0]            prod;
  logic                     res_load;
  logic [ZSC_SIGW-1:0]      sig_calc;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign mul_start = state == ST_ISSUE;
  assign res_load  = (state == ST_OUT) && (!result_valid || !result_stall);

  assign e_calc     = EW'(WINDOW) * EW'(spread) - EW'(sum);
  assign e_abs      = e_r[EW-1] ? -e_r : e_r;
  assign sum_abs    = sum[SW-1] ? -sum : sum;
  assign old_abs    = old_r[ZSC_DW-1] ? -old_r : old_r;
  assign spread_abs = spread[ZSC_DW-1] ? -spread : spread;
  assign lhs_ext    = CMPW'(lhs);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op) inside
      OP_EE: begin
        mul_a = AW'(e_abs[EMW-1:0]);
        mul_b = BW'(e_abs[EMW-1:0]);
      end
      OP_NQ: begin
        mul_a = AW'(sqsum);
        mul_b = BW'(WINDOW);
      end
      OP_SS: begin
        mul_a = AW'(sum_abs[SMW-1:0]);
        mul_b = BW'(sum_abs[SMW-1:0]);
      end
      OP_TT: begin
        mul_a = AW'(entry_thr);
        mul_b = BW'(entry_thr);
      end
      OP_XX: begin
        mul_a = AW'(exit_thr);
        mul_b = BW'(exit_thr);
      end
      OP_VT, OP_VX: begin
        mul_a = v;
        mul_b = BW'(coef);
      end
      OP_OLD: begin
        mul_a = AW'(old_abs[ZSC_MW-1:0]);
        mul_b = BW'(old_abs[ZSC_MW-1:0]);
      end
      OP_DD: begin
        mul_a = AW'(spread_abs[ZSC_MW-1:0]);
        mul_b = BW'(spread_abs[ZSC_MW-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // op order: scoring ops, then the two squares for the window update; warm-up items start at the squares
  always_comb begin
    unique case (op)
      OP_EE:   op_next = OP_NQ;
      OP_NQ:   op_next = OP_SS;
      OP_SS:   op_next = OP_TT;
      OP_TT:   op_next = OP_VT;
      OP_VT:   op_next = OP_XX;
      OP_XX:   op_next = OP_VX;
      OP_VX:   op_next = OP_OLD;
      OP_OLD:  op_next = OP_DD;
      default: op_next = OP_DD;
    endcase
  end

  always_comb begin
    if (warm) begin
      sig_calc = SIG_WARM;
    end else if (enter_flag) begin
      sig_calc = e_r[EW-1] ? SIG_SHORT : SIG_LONG;
    end else if (close_flag) begin
      sig_calc = SIG_CLOSE;
    end else begin
      sig_calc = SIG_NONE;
    end
  end

  zsc_mul #(
    .AW (AW),
    .BW (BW),
    .PW (PW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mst),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_EE;
      slot         <= '0;
      sum          <= '0;
      sqsum        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_load || (result_valid && result_stall);
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          op    <= warm ? OP_OLD : OP_EE;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mst.done) begin
            if (op == OP_DD) begin
              state <= ST_UPD;
            end else begin
              op    <= op_next;
              state <= ST_ISSUE;
            end
          end
        end
        ST_UPD: begin
          sum   <= sum - SW'(old_r) + SW'(spread);
          sqsum <= sqsum - QW'(oldsq) + QW'(dsq);
          slot  <= (slot == CLW'(WINDOW - 1)) ? '0 : slot + 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      spread <= q_item.spread;
      warm   <= q_item.warm;
    end
    if (state == ST_PREP) begin
      // slots not yet written during warm-up count as zero
      old_r <= warm ? '0 : mem_q;
      e_r   <= e_calc;
    end
    if ((state == ST_WAIT) && mst.done) begin
      case (op)
        OP_EE:  lhs <= {prod[2*EMW-1:0], {ZSC_ZSHIFT{1'b0}}};
        OP_NQ:  v <= prod[VW-1:0];
        OP_SS:  v <= v - prod[VW-1:0];
        OP_TT:  coef <= prod[CW-1:0];
        OP_XX:  coef <= prod[CW-1:0];
        OP_VT:  enter_flag <= lhs_ext > prod[CMPW-1:0];
        OP_VX:  close_flag <= lhs_ext < prod[CMPW-1:0];
        OP_OLD: oldsq <= prod[SQW-1:0];
        OP_DD:  dsq <= prod[SQW-1:0];
        default: ;
      endcase
    end
    if (res_load) begin
      signal <= sig_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      win_mem[slot] <= spread;
    end
    mem_q <= win_mem[slot];
  end

  `ZSC_ASSERT_SAME(a_mul_idle_on_start, clk, rst, mul_start, !mst.busy, "multiplier restarted while busy")
  `ZSC_ASSERT_SAME(a_done_in_wait, clk, rst, mst.done, state == ST_WAIT, "product ready outside wait")
  `ZSC_ASSERT_NEXT(a_out_holds, clk, rst, (state == ST_OUT) && result_valid && result_stall, state == ST_OUT, "result dropped under stall")
  `ZSC_ASSERT_NEXT(a_warm_code, clk, rst, res_load && warm, result_valid && (signal == SIG_WARM), "warm-up item scored")

endmodule

// ===== src/rolling_zscore_signal.sv =====
// Each item takes K multiplies in the back end, where K = 2 multiplies for a warm-up item
// and K = 9 for a scored one, each over NCH multiplier digits (2 at WINDOW=8). The back
// end scores one item at a time and takes no new item until the last is through, set by the one shared
// 16-bit-digit multiplier in the back end; a 2-item queue and the result register let
// input and output stall independently. Synchronous active-high reset clears window
// sums, fill count and handshakes; thresholds return to 1.0 and about 0.8 (Q4.12).
module rolling_zscore_signal import zsc_pkg::*; #(
  parameter int WINDOW = ZSC_WINDOW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [ZSC_PRICE_W-1:0]  price_a,
  input  logic [ZSC_PRICE_W-1:0]  price_b,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [ZSC_SIGW-1:0]     signal,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ZSC_CFG_IDXW-1:0] cfg_index,
  input  logic [ZSC_TW-1:0]       cfg_data
);

  // Configuration: thresholds are to be written by the user only while the block is idle
  // (the block does not enforce this), so the back end reads them directly without a shadow copy.
  logic [ZSC_TW-1:0] entry_thr;
  logic [ZSC_TW-1:0] exit_thr;

  // Front to back queue
  zsc_item_t q_din;
  zsc_item_t q_dout;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  // register decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_thr <= ENTRY_RESET;
      exit_thr  <= EXIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENTRY: entry_thr <= cfg_data;
        CFG_EXIT:  exit_thr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: forms the spread and tags warm-up items
  zsc_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .price_a    (price_a),
    .price_b    (price_b),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_din)
  );

  zsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: window memory, running sums, squared-term compare, result register
  zsc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_dout),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .entry_thr    (entry_thr),
    .exit_thr     (exit_thr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .signal       (signal)
  );

endmodule

// ===== verif/zscore_signal_checker.sv =====
`timescale 1ns / 1ps

module zscore_signal_checker import zsc_pkg::*; #(
  parameter int WINDOW = ZSC_WINDOW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic                    item_stall,
  input  logic [ZSC_PRICE_W-1:0]  price_a,
  input  logic [ZSC_PRICE_W-1:0]  price_b,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic [ZSC_SIGW-1:0]     signal,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [ZSC_CFG_IDXW-1:0] cfg_index,
  input  logic [ZSC_TW-1:0]       cfg_data,
  output int                      fail_count,
  output int                      pending
);

  logic signed [ZSC_DW-1:0] spreads [WINDOW];
  int unsigned              oldest;
  int unsigned              held;
  longint                   spread_sum;
  longint                   spread_sq_sum;
  logic [ZSC_TW-1:0]        entry_level;
  logic [ZSC_TW-1:0]        exit_level;
  logic [ZSC_SIGW-1:0]      expected_signals [$];
  int                       fails;

  // z tests done exactly on squares: e = N*d - S, V = N*Q - S*S
  function automatic logic [ZSC_SIGW-1:0] score_spread(input longint d);
    longint          excess;
    longint unsigned excess_mag;
    longint unsigned sum_mag;
    longint unsigned spread_var;
    logic [127:0]    lhs;
    logic [127:0]    entry_rhs;
    logic [127:0]    exit_rhs;
    excess     = longint'(WINDOW) * d - spread_sum;
    excess_mag = (excess < 0) ? -excess : excess;
    sum_mag    = (spread_sum < 0) ? -spread_sum : spread_sum;
    spread_var = longint'(WINDOW) * spread_sq_sum - sum_mag * sum_mag;
    lhs        = (128'(excess_mag) * 128'(excess_mag)) << ZSC_ZSHIFT;
    entry_rhs  = 128'(spread_var) * 128'(entry_level) * 128'(entry_level);
    exit_rhs   = 128'(spread_var) * 128'(exit_level) * 128'(exit_level);
    if (lhs > entry_rhs && excess > 0) return SIG_LONG;
    if (lhs > entry_rhs && excess < 0) return SIG_SHORT;
    if (lhs < exit_rhs) return SIG_CLOSE;
    return SIG_NONE;
  endfunction

  // new spread overwrites the oldest slot; sums kept exact
  task automatic push_spread(input longint d);
    longint old;
    old             = longint'(spreads[oldest]);
    spread_sum      = spread_sum - old + d;
    spread_sq_sum   = spread_sq_sum - old * old + d * d;
    spreads[oldest] = d[ZSC_DW-1:0];
    oldest          = (oldest == WINDOW - 1) ? 0 : oldest + 1;
  endtask

  always @(posedge clk) begin : watch
    longint              spread;
    logic [ZSC_SIGW-1:0] due;
    logic [ZSC_SIGW-1:0] predicted;
    if (rst) begin
      foreach (spreads[i]) spreads[i] = '0;
      oldest        = 0;
      held          = 0;
      spread_sum    = 0;
      spread_sq_sum = 0;
      entry_level   = ENTRY_RESET;
      exit_level    = EXIT_RESET;
      expected_signals.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY: entry_level = cfg_data;
          CFG_EXIT:  exit_level  = cfg_data;
          default: ;
        endcase
      end
      // results first, so an item taken this edge cannot match them
      if (result_valid && !result_stall) begin
        if (expected_signals.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual signal %0d", $time, signal);
        end else begin
          due = expected_signals.pop_front();
          if (signal !== due) begin
            fails++;
            $display("%0t: signal mismatch, expected %0d, actual %0d", $time, due, signal);
          end
        end
      end
      if (item_valid && !item_stall) begin
        spread = longint'(price_a) - longint'(price_b);
        if (held < WINDOW) begin
          held++;
          predicted = SIG_WARM;
        end else begin
          predicted = score_spread(spread);
        end
        push_spread(spread);
        expected_signals = {expected_signals, predicted};
      end
    end
    fail_count <= fails;
    pending    <= expected_signals.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import zsc_pkg::*;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_PHASES      = 7;
  localparam int CALM_PHASE      = 4;    // no idling on either side
  localparam int HOLD_PHASE      = 2;    // receiver holds off mid-phase
  localparam int HOLD_START      = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 64;   // above the scored latency
  localparam int QUIET_LIMIT     = 4000;
  localparam int PRICE_TOP       = 16777215;
  localparam int NOISE_TOP       = 511;

  // indexes the block ignores
  localparam logic [ZSC_CFG_IDXW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ZSC_CFG_IDXW-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [ZSC_PRICE_W-1:0]  PRICE_MAX    = '1;

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    item_valid   = 1'b0;
  logic                    item_stall;
  logic [ZSC_PRICE_W-1:0]  price_a      = '0;
  logic [ZSC_PRICE_W-1:0]  price_b      = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [ZSC_SIGW-1:0]     signal;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [ZSC_CFG_IDXW-1:0] cfg_index    = '0;
  logic [ZSC_TW-1:0]       cfg_data     = '0;

  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;   // set for the phase with no idling
  int   hold_req     = 0;      // bumped by stimulus to ask for a long hold
  int   hold_served  = 0;      // holds the receiver has carried out

  // price generator state: a drifting cluster plus runs of one fixed pair
  int                      base_a;
  int                      base_b;
  int                      run_left = 0;
  logic [ZSC_PRICE_W-1:0]  run_a;
  logic [ZSC_PRICE_W-1:0]  run_b;

  rolling_zscore_signal #(.WINDOW(ZSC_WINDOW)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .price_a      (price_a),
    .price_b      (price_b),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .signal       (signal),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  zscore_signal_checker #(.WINDOW(ZSC_WINDOW)) signal_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .price_a      (price_a),
    .price_b      (price_b),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .signal       (signal),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stalls at random about 20% of the time, none in the calm phase.
  // On request it holds off for a fixed stretch so the block backs up into
  // its input queue and stalls the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  // Watchdog: too long with nothing moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with random gaps first, and returns at the edge that
  // takes it. Valid is left high so back-to-back items need no re-raise.
  task automatic send_pair(input logic [ZSC_PRICE_W-1:0] a, b);
    while (!calm && $urandom_range(99) < 20) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    price_a    <= a;
    price_b    <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Register write; the caller drops cfg_valid after the last one.
  task automatic write_reg(input logic [ZSC_CFG_IDXW-1:0] index,
                           input logic [ZSC_TW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Sender stops, every outstanding result is collected, then the block is
  // given time to settle before anything is reconfigured.
  task automatic wait_drained;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly prices clustered round a slowly moving base, so the window
  // carries a real spread distribution; runs of one fixed pair flatten the
  // window to zero variance; the rest are outliers and full-range noise.
  task automatic random_pair(output logic [ZSC_PRICE_W-1:0] a, b);
    int pick;
    pick = $urandom_range(99);
    if (run_left > 0) begin
      run_left--;
      a = run_a;
      b = run_b;
    end else if (pick < 8) begin
      run_left = $urandom_range(12, 7);
      run_a    = ZSC_PRICE_W'(base_a + $urandom_range(NOISE_TOP));
      run_b    = ZSC_PRICE_W'(base_b + $urandom_range(NOISE_TOP));
      a        = run_a;
      b        = run_b;
    end else if (pick < 63) begin
      if ($urandom_range(99) < 3) begin
        base_a = $urandom_range(PRICE_TOP - NOISE_TOP);
        base_b = $urandom_range(PRICE_TOP - NOISE_TOP);
      end
      a = ZSC_PRICE_W'(base_a + $urandom_range(NOISE_TOP));
      b = ZSC_PRICE_W'(base_b + $urandom_range(NOISE_TOP));
    end else if (pick < 83) begin
      a = ZSC_PRICE_W'($urandom_range(PRICE_TOP));
      b = ZSC_PRICE_W'($urandom_range(PRICE_TOP));
    end else begin
      a = $urandom_range(1) ? PRICE_MAX : '0;
      b = $urandom_range(1) ? ZSC_PRICE_W'($urandom_range(PRICE_TOP))
                            : ($urandom_range(1) ? PRICE_MAX : '0);
    end
  endtask

  initial begin
    logic [ZSC_PRICE_W-1:0] a;
    logic [ZSC_PRICE_W-1:0] b;
    logic [ZSC_TW-1:0]      entry_set;
    logic [ZSC_TW-1:0]      exit_set;
    base_a = $urandom_range(PRICE_TOP - NOISE_TOP);
    base_b = $urandom_range(PRICE_TOP - NOISE_TOP);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset thresholds. Warm-up with zero spreads at both ends
    // of the price range and with alternating bit patterns.
    send_pair('0, '0);
    send_pair(PRICE_MAX, PRICE_MAX);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h555555, 24'h555555);
    send_pair(24'hAAAAAA, 24'hAAAAAA);
    send_pair(24'h000001, 24'h000001);
    send_pair(24'hFFFFFE, 24'hFFFFFE);
    // flat window: spread on the mean gives none, one above gives long
    send_pair(24'h000005, 24'h000005);
    send_pair(24'h000006, 24'h000005);
    // most negative spread against a nearly flat window: short
    send_pair('0, PRICE_MAX);
    // refill flat at the most positive spread, then sit on the mean
    repeat (8) send_pair(PRICE_MAX, '0);
    send_pair(PRICE_MAX, '0);
    // below a flat window: short
    send_pair('0, '0);
    // close to the mean of seven maxima and a zero: close
    send_pair(24'hE00000, '0);

    // Random phases, each under its own thresholds.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin           // zero entry threshold: any nonzero excess enters
          entry_set = '0;
          exit_set  = '0;
        end
        1: begin           // both at the top
          entry_set = '1;
          exit_set  = '1;
        end
        2: begin           // exit above entry, entry tests win
          entry_set = 16'd2048;
          exit_set  = 16'd6144;
        end
        3: begin
          entry_set = '1;
          exit_set  = '0;
        end
        4: begin
          entry_set = 16'($urandom);
          exit_set  = 16'($urandom);
        end
        5: begin
          entry_set = 16'($urandom_range(12288, 2048));
          exit_set  = 16'($urandom_range(4096));
        end
        default: begin     // back to the reset values
          entry_set = ENTRY_RESET;
          exit_set  = EXIT_RESET;
        end
      endcase
      write_reg(CFG_ENTRY, entry_set);
      write_reg(CFG_EXIT, exit_set);
      // spare indexes must leave both thresholds alone
      if (p == 1) write_reg(CFG_SPARE_LO, '1);
      if (p == 5) write_reg(CFG_SPARE_HI, 16'($urandom));
      cfg_valid <= 1'b0;
      calm = (p == CALM_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == HOLD_PHASE && i == HOLD_START) hold_req++;
        random_pair(a, b);
        send_pair(a, b);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
